// File: sv/dbos_pkg.sv
`default_nettype none

package dbos_pkg;

	// Frame history and counter sizing.
	localparam int HISTORY_DEPTH = 20;
	localparam int COUNT_WIDTH   = 16;
	localparam int POINTS_WIDTH  = 16;
	localparam int LIMIT_WIDTH   = 16;
	localparam int CMP_WIDTH     = (COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH;
	localparam int HIST_PTR_W    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

	// Queue between the front and the back, and the result queue.
	localparam int OPQ_DEPTH  = 4;
	localparam int OPQ_PTR_W  = $clog2(OPQ_DEPTH);
	localparam int OPQ_CNT_W  = $clog2(OPQ_DEPTH + 1);
	localparam int RESQ_DEPTH = 2;
	localparam int RESQ_PTR_W = $clog2(RESQ_DEPTH);
	localparam int RESQ_CNT_W = $clog2(RESQ_DEPTH + 1);

	// Register port.
	localparam int NUM_REGS   = 8;
	localparam int APB_ADDR_W = $clog2(NUM_REGS) + 2;
	localparam int APB_DATA_W = 32;

	// Box bounds are held in doubled millimetres.
	localparam int BOUND_W = 20;

	typedef enum logic [$clog2(NUM_REGS)-1:0] {
		REG_VEHICLE_LENGTH = 3'd0,
		REG_VEHICLE_WIDTH  = 3'd1,
		REG_SAFETY_MARGIN  = 3'd2,
		REG_BOX_EXTENT     = 3'd3,
		REG_HEIGHT_LOW     = 3'd4,
		REG_HEIGHT_HIGH    = 3'd5,
		REG_COUNT_LIMIT    = 3'd6,
		REG_SPEED_LIMIT    = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		REQ_POINT    = 2'd0,
		REQ_FRAME    = 2'd1,
		REQ_VELOCITY = 2'd2
	} req_t;

	typedef enum logic {
		OP_COUNT = 1'b0,
		OP_FRAME = 1'b1
	} op_kind_t;

	typedef struct packed {
		op_kind_t kind;
		logic     lidar;
	} op_t;

	typedef logic signed [BOUND_W-1:0] bound_t;

	typedef struct packed {
		bound_t near_x;
		bound_t far_x;
		bound_t near_y;
		bound_t far_y;
		bound_t half_l;
		bound_t half_w;
		bound_t neg_near_x;
		bound_t neg_far_x;
		bound_t neg_near_y;
		bound_t neg_far_y;
		bound_t neg_half_l;
		bound_t neg_half_w;
	} box_bounds_t;

	typedef struct packed {
		box_bounds_t        bounds;
		logic signed [15:0] height_low;
		logic signed [15:0] height_high;
		logic [14:0]        speed_limit;
	} front_cfg_t;

	typedef logic [COUNT_WIDTH-1:0]  count_t;
	typedef logic [CMP_WIDTH-1:0]    cmp_t;
	typedef logic [HIST_PTR_W-1:0]   hist_ptr_t;
	typedef logic [POINTS_WIDTH-1:0] points_t;
	typedef logic [LIMIT_WIDTH-1:0]  limit_t;

	typedef struct packed {
		logic    stop;
		points_t points;
		logic    lidar;
	} result_t;

endpackage

`default_nettype wire

// File: sv/dbos_cfg.sv
`default_nettype none

module dbos_cfg (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               psel,
	input  wire                               penable,
	input  wire                               pwrite,
	input  wire  [dbos_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire  [dbos_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [dbos_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready,
	output dbos_pkg::front_cfg_t              front_cfg,
	output dbos_pkg::limit_t                  count_limit
);

	logic [13:0]        veh_len_q;
	logic [13:0]        veh_wid_q;
	logic [13:0]        margin_q;
	logic [13:0]        extent_q;
	logic signed [15:0] height_low_q;
	logic signed [15:0] height_high_q;
	logic [15:0]        count_limit_q;
	logic [14:0]        speed_limit_q;

	dbos_pkg::reg_idx_t    idx;
	logic                  wr_en;
	dbos_pkg::bound_t      near_x, far_x, near_y, far_y, half_l, half_w;
	dbos_pkg::box_bounds_t bounds_q;

	assign pready = 1'b1;
	assign idx    = dbos_pkg::reg_idx_t'(paddr[dbos_pkg::APB_ADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite;

	// Register file, written in the access phase of a write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			veh_len_q     <= 14'd800;
			veh_wid_q     <= 14'd500;
			margin_q      <= 14'd200;
			extent_q      <= 14'd1000;
			height_low_q  <= -16'sd1000;
			height_high_q <= -16'sd300;
			count_limit_q <= 16'd20;
			speed_limit_q <= 15'd200;
		end else if (wr_en) begin
			case (idx)
				dbos_pkg::REG_VEHICLE_LENGTH: veh_len_q     <= pwdata[13:0];
				dbos_pkg::REG_VEHICLE_WIDTH:  veh_wid_q     <= pwdata[13:0];
				dbos_pkg::REG_SAFETY_MARGIN:  margin_q      <= pwdata[13:0];
				dbos_pkg::REG_BOX_EXTENT:     extent_q      <= pwdata[13:0];
				dbos_pkg::REG_HEIGHT_LOW:     height_low_q  <= $signed(pwdata[15:0]);
				dbos_pkg::REG_HEIGHT_HIGH:    height_high_q <= $signed(pwdata[15:0]);
				dbos_pkg::REG_COUNT_LIMIT:    count_limit_q <= pwdata[15:0];
				dbos_pkg::REG_SPEED_LIMIT:    speed_limit_q <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	// Read data; signed registers read back sign extended.
	always_comb begin
		case (idx)
			dbos_pkg::REG_VEHICLE_LENGTH: prdata = {18'd0, veh_len_q};
			dbos_pkg::REG_VEHICLE_WIDTH:  prdata = {18'd0, veh_wid_q};
			dbos_pkg::REG_SAFETY_MARGIN:  prdata = {18'd0, margin_q};
			dbos_pkg::REG_BOX_EXTENT:     prdata = {18'd0, extent_q};
			dbos_pkg::REG_HEIGHT_LOW:     prdata = {{16{height_low_q[15]}}, height_low_q};
			dbos_pkg::REG_HEIGHT_HIGH:    prdata = {{16{height_high_q[15]}}, height_high_q};
			dbos_pkg::REG_COUNT_LIMIT:    prdata = {16'd0, count_limit_q};
			dbos_pkg::REG_SPEED_LIMIT:    prdata = {17'd0, speed_limit_q};
			default:                      prdata = '0;
		endcase
	end

	// Box edges in doubled millimetres: vehicle size plus twice the margin and extent.
	always_comb begin
		half_l = dbos_pkg::bound_t'(veh_len_q);
		half_w = dbos_pkg::bound_t'(veh_wid_q);
		near_x = half_l + dbos_pkg::bound_t'({margin_q, 1'b0});
		far_x  = near_x + dbos_pkg::bound_t'({extent_q, 1'b0});
		near_y = half_w + dbos_pkg::bound_t'({margin_q, 1'b0});
		far_y  = near_y + dbos_pkg::bound_t'({extent_q, 1'b0});
	end

	// The edges and their negatives are registered, so the point path only compares.
	always_ff @(posedge clk) begin
		bounds_q.near_x     <= near_x;
		bounds_q.far_x      <= far_x;
		bounds_q.near_y     <= near_y;
		bounds_q.far_y      <= far_y;
		bounds_q.half_l     <= half_l;
		bounds_q.half_w     <= half_w;
		bounds_q.neg_near_x <= -near_x;
		bounds_q.neg_far_x  <= -far_x;
		bounds_q.neg_near_y <= -near_y;
		bounds_q.neg_far_y  <= -far_y;
		bounds_q.neg_half_l <= -half_l;
		bounds_q.neg_half_w <= -half_w;
	end

	assign front_cfg.bounds      = bounds_q;
	assign front_cfg.height_low  = height_low_q;
	assign front_cfg.height_high = height_high_q;
	assign front_cfg.speed_limit = speed_limit_q;
	assign count_limit           = count_limit_q;

endmodule

`default_nettype wire

// File: sv/dbos_front.sv
`default_nettype none

module dbos_front (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        push,
	output logic                       full,
	input  wire  [1:0]                 req_type,
	input  wire                        lidar_source,
	input  wire  signed [15:0]         point_x_mm,
	input  wire  signed [15:0]         point_y_mm,
	input  wire  signed [15:0]         point_z_mm,
	input  wire  signed [15:0]         speed_x_mm_s,
	input  wire  signed [15:0]         speed_y_mm_s,
	input  dbos_pkg::front_cfg_t       front_cfg,
	input  wire                        op_full,
	output logic                       op_push,
	output dbos_pkg::op_t              op_data
);

	typedef enum logic [2:0] {
		DIR_FORWARD  = 3'd0,
		DIR_BACKWARD = 3'd1,
		DIR_LEFT     = 3'd2,
		DIR_RIGHT    = 3'd3,
		DIR_STOPPED  = 3'd4
	} dir_t;

	logic               valid_s1;
	dbos_pkg::req_t     req_s1;
	logic               src_s1;
	logic signed [15:0] x_s1, y_s1, z_s1, vx_s1, vy_s1;

	dir_t dir_q;
	logic lidar_q;

	logic             go;
	logic [16:0]      abs_x, abs_y, thr;
	logic             x_moving, y_moving, x_slow, y_slow, vx_pos, vy_pos;
	dir_t             dir_nxt;
	logic             lidar_nxt;
	dbos_pkg::bound_t x2, y2, x_lo, x_hi, y_lo, y_hi;
	logic             z_ok, in_box, from_active;

	// The input stage holds while the queue to the back is full.
	assign full = valid_s1 & op_full;
	assign go   = valid_s1 & ~op_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!full) begin
			valid_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			req_s1 <= dbos_pkg::req_t'(req_type);
			src_s1 <= lidar_source;
			x_s1   <= point_x_mm;
			y_s1   <= point_y_mm;
			z_s1   <= point_z_mm;
			vx_s1  <= speed_x_mm_s;
			vy_s1  <= speed_y_mm_s;
		end
	end

	// Speed magnitudes, 17 bits so that the most negative speed stays exact.
	always_comb begin
		abs_x    = vx_s1[15] ? (17'd0 - {vx_s1[15], vx_s1}) : {1'b0, vx_s1};
		abs_y    = vy_s1[15] ? (17'd0 - {vy_s1[15], vy_s1}) : {1'b0, vy_s1};
		thr      = {2'b00, front_cfg.speed_limit};
		x_moving = abs_x > thr;
		y_moving = abs_y > thr;
		x_slow   = abs_x < thr;
		y_slow   = abs_y < thr;
		vx_pos   = !vx_s1[15] && (vx_s1 != 16'sd0);
		vy_pos   = !vy_s1[15] && (vy_s1 != 16'sd0);
	end

	// Direction choice; a stop keeps the lidar that was selected.
	always_comb begin
		lidar_nxt = lidar_q;
		if (x_moving && y_slow) begin
			dir_nxt   = vx_pos ? DIR_FORWARD : DIR_BACKWARD;
			lidar_nxt = !vx_pos;
		end else if (y_moving && x_slow) begin
			dir_nxt   = vy_pos ? DIR_LEFT : DIR_RIGHT;
			lidar_nxt = !vy_pos;
		end else begin
			dir_nxt = DIR_STOPPED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q   <= DIR_FORWARD;
			lidar_q <= 1'b0;
		end else if (go && req_s1 == dbos_pkg::REQ_VELOCITY) begin
			dir_q   <= dir_nxt;
			lidar_q <= lidar_nxt;
		end
	end

	// Crop box of the current direction.
	always_comb begin
		case (dir_q)
			DIR_FORWARD: begin
				x_lo = front_cfg.bounds.near_x;
				x_hi = front_cfg.bounds.far_x;
				y_lo = front_cfg.bounds.neg_half_w;
				y_hi = front_cfg.bounds.half_w;
			end
			DIR_BACKWARD: begin
				x_lo = front_cfg.bounds.neg_far_x;
				x_hi = front_cfg.bounds.neg_near_x;
				y_lo = front_cfg.bounds.neg_half_w;
				y_hi = front_cfg.bounds.half_w;
			end
			DIR_LEFT: begin
				x_lo = front_cfg.bounds.neg_half_l;
				x_hi = front_cfg.bounds.half_l;
				y_lo = front_cfg.bounds.near_y;
				y_hi = front_cfg.bounds.far_y;
			end
			DIR_RIGHT: begin
				x_lo = front_cfg.bounds.neg_half_l;
				x_hi = front_cfg.bounds.half_l;
				y_lo = front_cfg.bounds.neg_far_y;
				y_hi = front_cfg.bounds.neg_near_y;
			end
			default: begin
				x_lo = front_cfg.bounds.neg_near_x;
				x_hi = front_cfg.bounds.near_x;
				y_lo = front_cfg.bounds.neg_near_y;
				y_hi = front_cfg.bounds.near_y;
			end
		endcase
	end

	// Inclusive box test on doubled coordinates.
	always_comb begin
		x2     = dbos_pkg::bound_t'($signed({x_s1, 1'b0}));
		y2     = dbos_pkg::bound_t'($signed({y_s1, 1'b0}));
		z_ok   = (z_s1 >= front_cfg.height_low) && (z_s1 <= front_cfg.height_high);
		in_box = z_ok && (x2 >= x_lo) && (x2 <= x_hi) && (y2 >= y_lo) && (y2 <= y_hi);
		from_active = (src_s1 == lidar_q);
	end

	// Only counted points and frame ends of the active lidar go to the back.
	always_comb begin
		op_data.lidar = lidar_q;
		case (req_s1)
			dbos_pkg::REQ_POINT: begin
				op_push      = go && from_active && in_box;
				op_data.kind = dbos_pkg::OP_COUNT;
			end
			dbos_pkg::REQ_FRAME: begin
				op_push      = go && from_active;
				op_data.kind = dbos_pkg::OP_FRAME;
			end
			default: begin
				op_push      = 1'b0;
				op_data.kind = dbos_pkg::OP_COUNT;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: sv/dbos_opq.sv
`default_nettype none

module dbos_opq (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push_en,
	input  dbos_pkg::op_t      push_data,
	output logic               full,
	input  wire                pop_en,
	output logic               empty,
	output dbos_pkg::op_t      head
);

	dbos_pkg::op_t                  entry_q [dbos_pkg::OPQ_DEPTH];
	logic [dbos_pkg::OPQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [dbos_pkg::OPQ_CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == dbos_pkg::OPQ_CNT_W'(dbos_pkg::OPQ_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = entry_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push_en) begin
				wr_ptr_q <= (wr_ptr_q == dbos_pkg::OPQ_PTR_W'(dbos_pkg::OPQ_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop_en) begin
				rd_ptr_q <= (rd_ptr_q == dbos_pkg::OPQ_PTR_W'(dbos_pkg::OPQ_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push_en && !pop_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop_en && !push_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_en) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// File: sv/dbos_back.sv
`default_nettype none

module dbos_back (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                op_empty,
	input  dbos_pkg::op_t      op_head,
	output logic               op_pop,
	input  dbos_pkg::limit_t   count_limit,
	input  wire                pop,
	output logic               empty,
	output logic               obstacle_halt,
	output logic [15:0]        frame_points,
	output logic               active_lidar
);

	dbos_pkg::count_t                    counter_q;
	dbos_pkg::count_t                    hist_q [dbos_pkg::HISTORY_DEPTH];
	logic [dbos_pkg::HISTORY_DEPTH-1:0]  gt_q;
	dbos_pkg::hist_ptr_t                 pos_q;

	dbos_pkg::result_t               res_q [dbos_pkg::RESQ_DEPTH];
	logic [dbos_pkg::RESQ_PTR_W-1:0] res_wr_q, res_rd_q;
	logic [dbos_pkg::RESQ_CNT_W-1:0] res_cnt_q;

	logic                               res_full, res_pop, do_frame, do_count;
	logic                               new_gt;
	logic [dbos_pkg::HISTORY_DEPTH-1:0] pos_mask;
	dbos_pkg::result_t                  res_new;

	assign res_full = (res_cnt_q == dbos_pkg::RESQ_CNT_W'(dbos_pkg::RESQ_DEPTH));
	assign empty    = (res_cnt_q == '0);
	assign res_pop  = pop && !empty;

	// A count beat always drains; a frame beat waits for room in the result queue.
	assign op_pop   = !op_empty && ((op_head.kind == dbos_pkg::OP_COUNT) || !res_full);
	assign do_count = op_pop && (op_head.kind == dbos_pkg::OP_COUNT);
	assign do_frame = op_pop && (op_head.kind == dbos_pkg::OP_FRAME);

	// Stop decision: stored over-limit marks, with the slot being replaced taken from
	// the count that enters it.
	always_comb begin
		new_gt = dbos_pkg::cmp_t'(counter_q) > dbos_pkg::cmp_t'(count_limit);
		for (int i = 0; i < dbos_pkg::HISTORY_DEPTH; i++) begin
			pos_mask[i] = (pos_q == dbos_pkg::hist_ptr_t'(i));
		end
		res_new.stop   = new_gt | (|(gt_q & ~pos_mask));
		res_new.points = dbos_pkg::points_t'(counter_q);
		res_new.lidar  = op_head.lidar;
	end

	// Saturating frame counter, history ring and over-limit marks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
			pos_q     <= '0;
			gt_q      <= '0;
			for (int i = 0; i < dbos_pkg::HISTORY_DEPTH; i++) begin
				hist_q[i] <= '0;
			end
		end else begin
			if (do_count && (counter_q != '1)) begin
				counter_q <= counter_q + 1'b1;
			end else if (do_frame) begin
				counter_q <= '0;
			end
			if (do_frame) begin
				pos_q <= (pos_q == dbos_pkg::hist_ptr_t'(dbos_pkg::HISTORY_DEPTH - 1)) ?
					'0 : pos_q + 1'b1;
			end
			for (int i = 0; i < dbos_pkg::HISTORY_DEPTH; i++) begin
				if (do_frame && pos_mask[i]) begin
					hist_q[i] <= counter_q;
					gt_q[i]   <= new_gt;
				end else begin
					gt_q[i]   <= dbos_pkg::cmp_t'(hist_q[i]) > dbos_pkg::cmp_t'(count_limit);
				end
			end
		end
	end

	// Result queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wr_q  <= '0;
			res_rd_q  <= '0;
			res_cnt_q <= '0;
		end else begin
			if (do_frame) begin
				res_wr_q <= (res_wr_q == dbos_pkg::RESQ_PTR_W'(dbos_pkg::RESQ_DEPTH - 1)) ?
					'0 : res_wr_q + 1'b1;
			end
			if (res_pop) begin
				res_rd_q <= (res_rd_q == dbos_pkg::RESQ_PTR_W'(dbos_pkg::RESQ_DEPTH - 1)) ?
					'0 : res_rd_q + 1'b1;
			end
			if (do_frame && !res_pop) begin
				res_cnt_q <= res_cnt_q + 1'b1;
			end else if (res_pop && !do_frame) begin
				res_cnt_q <= res_cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_frame) begin
			res_q[res_wr_q] <= res_new;
		end
	end

	assign obstacle_halt = res_q[res_rd_q].stop;
	assign frame_points  = res_q[res_rd_q].points;
	assign active_lidar  = res_q[res_rd_q].lidar;

endmodule

`default_nettype wire

// File: sv/direction_box_obstacle_stop.sv
// A frame end passes the input stage and the queue to the back; the back end then
// writes its result into the result queue.
// Throughput: one item per cycle; the front stalls only when its 4-entry queue is full,
// and a frame-end beat waits in the back only while the 2-entry result queue is full.
// Reset: arst_n clears direction (forward), lidar (first), count, history and queues,
// and loads the register defaults; no clearing pass is needed.
`default_nettype none

module direction_box_obstacle_stop (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               push,
	output logic                              full,
	input  wire  [1:0]                        req_type,
	input  wire                               lidar_source,
	input  wire  signed [15:0]                point_x_mm,
	input  wire  signed [15:0]                point_y_mm,
	input  wire  signed [15:0]                point_z_mm,
	input  wire  signed [15:0]                speed_x_mm_s,
	input  wire  signed [15:0]                speed_y_mm_s,
	output logic                              empty,
	input  wire                               pop,
	output logic                              obstacle_halt,
	output logic [15:0]                       frame_points,
	output logic                              active_lidar,
	input  wire                               psel,
	input  wire                               penable,
	input  wire                               pwrite,
	input  wire  [dbos_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire  [dbos_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [dbos_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready
);

	dbos_pkg::front_cfg_t front_cfg;
	dbos_pkg::limit_t     count_limit;
	logic                 op_push, op_full, op_pop, op_empty;
	dbos_pkg::op_t        op_data, op_head;

	// Register port.
	dbos_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.front_cfg   (front_cfg),
		.count_limit (count_limit)
	);

	// Front: takes items, tracks direction and lidar, classifies points.
	dbos_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.req_type     (req_type),
		.lidar_source (lidar_source),
		.point_x_mm   (point_x_mm),
		.point_y_mm   (point_y_mm),
		.point_z_mm   (point_z_mm),
		.speed_x_mm_s (speed_x_mm_s),
		.speed_y_mm_s (speed_y_mm_s),
		.front_cfg    (front_cfg),
		.op_full      (op_full),
		.op_push      (op_push),
		.op_data      (op_data)
	);

	// Queue between front and back.
	dbos_opq u_opq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_en   (op_push),
		.push_data (op_data),
		.full      (op_full),
		.pop_en    (op_pop),
		.empty     (op_empty),
		.head      (op_head)
	);

	// Back: counting, frame history and results.
	dbos_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.op_empty      (op_empty),
		.op_head       (op_head),
		.op_pop        (op_pop),
		.count_limit   (count_limit),
		.pop           (pop),
		.empty         (empty),
		.obstacle_halt (obstacle_halt),
		.frame_points  (frame_points),
		.active_lidar  (active_lidar)
	);

endmodule

`default_nettype wire

// File: sv/dbos_checker.sv
`default_nettype none

module dbos_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        push,
	input wire        full,
	input wire        empty,
	input wire        pop,
	input wire        obstacle_halt,
	input wire [15:0] frame_points,
	input wire        active_lidar,
	input wire        psel,
	input wire        penable,
	input wire        pwrite,
	input wire        pready
);

	// No result can be waiting at the first edge after reset is released.
	a_empty_after_reset: assert property (@(posedge clk) $rose(arst_n) |-> empty)
		else $error("result present right after reset");

	// The input side can only become full right after it accepted a beat.
	a_full_after_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push && !full))
		else $error("full rose without an accepted beat");

	// A waiting result holds until it is taken.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(obstacle_halt) && $stable(frame_points)
			&& $stable(active_lidar)))
		else $error("waiting result changed");

	// The register port never inserts wait states.
	a_pready_high: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable) |-> pready)
		else $error("pready low in access phase");

endmodule

bind direction_box_obstacle_stop dbos_checker u_dbos_checker (.*);

`default_nettype wire

// File: tb/direction_box_obstacle_stop_test.sv
`timescale 1ns / 1ps

module direction_box_obstacle_stop_test;

	// Travel directions as the detector numbers them.
	typedef enum logic [2:0] {
		HEAD_FORWARD  = 3'd0,
		HEAD_BACKWARD = 3'd1,
		HEAD_LEFT     = 3'd2,
		HEAD_RIGHT    = 3'd3,
		HEAD_STOPPED  = 3'd4
	} heading_t;

	typedef struct {
		logic [1:0]         kind;
		logic               src;
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic signed [15:0] pz;
		logic signed [15:0] vx;
		logic signed [15:0] vy;
	} lidar_item_t;

	localparam logic [1:0] REQ_UNKNOWN = 2'd3;
	localparam int GAP_MAX = 8;
	localparam int SETTLE_CYCLES = 12;
	localparam int PHASE_ITEMS = 75;
	localparam int LONG_FRAME_POINTS = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [1:0] req_type = dbos_pkg::REQ_POINT;
	logic lidar_source = 1'b0;
	logic signed [15:0] point_x_mm = '0;
	logic signed [15:0] point_y_mm = '0;
	logic signed [15:0] point_z_mm = '0;
	logic signed [15:0] speed_x_mm_s = '0;
	logic signed [15:0] speed_y_mm_s = '0;
	logic empty;
	logic pop = 1'b0;
	logic obstacle_halt;
	logic [15:0] frame_points;
	logic active_lidar;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [dbos_pkg::APB_ADDR_W-1:0] paddr = '0;
	logic [dbos_pkg::APB_DATA_W-1:0] pwdata = '0;
	logic [dbos_pkg::APB_DATA_W-1:0] prdata;
	logic pready;

	// Mirror of the register file.
	logic [13:0] cfg_length;
	logic [13:0] cfg_width;
	logic [13:0] cfg_margin;
	logic [13:0] cfg_extent;
	logic signed [15:0] cfg_z_low;
	logic signed [15:0] cfg_z_high;
	logic [15:0] cfg_count_limit;
	logic [14:0] cfg_speed_limit;

	// Mirror of the detector state.
	heading_t heading;
	logic lidar_sel;
	dbos_pkg::count_t frame_count;
	dbos_pkg::count_t history [dbos_pkg::HISTORY_DEPTH];
	int history_wr;

	dbos_pkg::result_t expected_frames[$];
	int errors = 0;
	int effective_items = 0;
	int tx_gap_max = GAP_MAX;
	int rx_gap_max = GAP_MAX;
	int rx_stall = 0;
	int rx_hold = 0;

	direction_box_obstacle_stop u_top (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.req_type(req_type),
		.lidar_source(lidar_source),
		.point_x_mm(point_x_mm),
		.point_y_mm(point_y_mm),
		.point_z_mm(point_z_mm),
		.speed_x_mm_s(speed_x_mm_s),
		.speed_y_mm_s(speed_y_mm_s),
		.empty(empty),
		.pop(pop),
		.obstacle_halt(obstacle_halt),
		.frame_points(frame_points),
		.active_lidar(active_lidar),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #1 clk = ~clk;

	function automatic void reset_detector_model();
		cfg_length = 14'd800;
		cfg_width = 14'd500;
		cfg_margin = 14'd200;
		cfg_extent = 14'd1000;
		cfg_z_low = -16'sd1000;
		cfg_z_high = -16'sd300;
		cfg_count_limit = 16'd20;
		cfg_speed_limit = 15'd200;
		heading = HEAD_FORWARD;
		lidar_sel = 1'b0;
		frame_count = '0;
		foreach (history[i])
			history[i] = '0;
		history_wr = 0;
	endfunction

	// Crop box of the current heading in doubled millimetres, bounds inclusive.
	function automatic void box_window(output int x_lo, output int x_hi,
			output int y_lo, output int y_hi);
		int len, wid, m2, s2;
		len = int'(cfg_length);
		wid = int'(cfg_width);
		m2 = 2 * int'(cfg_margin);
		s2 = 2 * int'(cfg_extent);
		case (heading)
		HEAD_FORWARD: begin
			x_lo = len + m2;
			x_hi = len + m2 + s2;
			y_lo = -wid;
			y_hi = wid;
		end
		HEAD_BACKWARD: begin
			x_lo = -len - m2 - s2;
			x_hi = -len - m2;
			y_lo = -wid;
			y_hi = wid;
		end
		HEAD_LEFT: begin
			x_lo = -len;
			x_hi = len;
			y_lo = wid + m2;
			y_hi = wid + m2 + s2;
		end
		HEAD_RIGHT: begin
			x_lo = -len;
			x_hi = len;
			y_lo = -wid - m2 - s2;
			y_hi = -wid - m2;
		end
		default: begin
			x_lo = -len - m2;
			x_hi = len + m2;
			y_lo = -wid - m2;
			y_hi = wid + m2;
		end
		endcase
	endfunction

	function automatic bit point_hits(logic signed [15:0] x, logic signed [15:0] y,
			logic signed [15:0] z);
		int x_lo, x_hi, y_lo, y_hi, x2, y2;
		box_window(x_lo, x_hi, y_lo, y_hi);
		x2 = 2 * int'(x);
		y2 = 2 * int'(y);
		return z >= cfg_z_low && z <= cfg_z_high && x2 >= x_lo && x2 <= x_hi &&
			y2 >= y_lo && y2 <= y_hi;
	endfunction

	// A command picks a direction only when one axis is clearly above the
	// threshold and the other clearly below it; otherwise the vehicle is stopped.
	function automatic void steer(logic signed [15:0] vx, logic signed [15:0] vy);
		int ax, ay, t;
		ax = (vx < 0) ? -int'(vx) : int'(vx);
		ay = (vy < 0) ? -int'(vy) : int'(vy);
		t = int'(cfg_speed_limit);
		if (ax > t && ay < t) begin
			heading = (vx > 0) ? HEAD_FORWARD : HEAD_BACKWARD;
			lidar_sel = (vx > 0) ? 1'b0 : 1'b1;
		end else if (ay > t && ax < t) begin
			heading = (vy > 0) ? HEAD_LEFT : HEAD_RIGHT;
			lidar_sel = (vy > 0) ? 1'b0 : 1'b1;
		end else begin
			heading = HEAD_STOPPED;
		end
	endfunction

	// Advance the model by one accepted item and queue the frame result it causes.
	function automatic void predict_item(lidar_item_t it);
		dbos_pkg::result_t res;
		bit over;
		case (it.kind)
		dbos_pkg::REQ_VELOCITY: begin
			steer(it.vx, it.vy);
			effective_items++;
		end
		dbos_pkg::REQ_POINT: begin
			if (it.src == lidar_sel) begin
				effective_items++;
				if (point_hits(it.px, it.py, it.pz) && frame_count != '1)
					frame_count++;
			end
		end
		dbos_pkg::REQ_FRAME: begin
			if (it.src == lidar_sel) begin
				effective_items++;
				history[history_wr] = frame_count;
				history_wr = (history_wr + 1 >= dbos_pkg::HISTORY_DEPTH) ? 0 : history_wr + 1;
				over = 1'b0;
				foreach (history[i])
					if (history[i] > cfg_count_limit)
						over = 1'b1;
				res.stop = over;
				res.points = frame_count[15:0];
				res.lidar = lidar_sel;
				expected_frames.insert(expected_frames.size(), res);
				frame_count = '0;
			end
		end
		default: ;
		endcase
	endfunction

	function automatic logic signed [15:0] clamp16(int v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return 16'(v);
	endfunction

	function automatic lidar_item_t make_point(logic src, logic signed [15:0] x,
			logic signed [15:0] y, logic signed [15:0] z);
		lidar_item_t it;
		it.kind = dbos_pkg::REQ_POINT;
		it.src = src;
		it.px = x;
		it.py = y;
		it.pz = z;
		it.vx = 16'($urandom);
		it.vy = 16'($urandom);
		return it;
	endfunction

	function automatic lidar_item_t random_point(logic src);
		return make_point(src, 16'($urandom), 16'($urandom), 16'($urandom));
	endfunction

	function automatic lidar_item_t make_frame(logic src);
		lidar_item_t it;
		it = random_point(src);
		it.kind = dbos_pkg::REQ_FRAME;
		return it;
	endfunction

	function automatic lidar_item_t make_unknown();
		lidar_item_t it;
		it = random_point(1'($urandom));
		it.kind = REQ_UNKNOWN;
		return it;
	endfunction

	// Point fields and the source bit are don't-cares on a command, so randomize them.
	function automatic lidar_item_t make_velocity(logic signed [15:0] vx,
			logic signed [15:0] vy);
		lidar_item_t it;
		it = random_point(1'($urandom));
		it.kind = dbos_pkg::REQ_VELOCITY;
		it.vx = vx;
		it.vy = vy;
		return it;
	endfunction

	// A coordinate on or near one bound of a range, or inside it.
	function automatic int near_coord(int lo, int hi);
		int off;
		off = int'($urandom_range(0, 6)) - 3;
		case ($urandom_range(0, 2))
		0: return lo + off;
		1: return hi + off;
		default: return (hi >= lo) ? lo + int'($urandom_range(0, hi - lo)) : lo;
		endcase
	endfunction

	function automatic lidar_item_t near_point(logic src);
		int x_lo, x_hi, y_lo, y_hi;
		if ($urandom_range(0, 9) < 2)
			return random_point(src);
		box_window(x_lo, x_hi, y_lo, y_hi);
		return make_point(src, clamp16(near_coord(x_lo, x_hi) / 2),
			clamp16(near_coord(y_lo, y_hi) / 2),
			clamp16(near_coord(int'(cfg_z_low), int'(cfg_z_high))));
	endfunction

	// Speeds chosen around the threshold so that every direction comes up.
	function automatic lidar_item_t random_velocity();
		int t, fast, slow;
		t = int'(cfg_speed_limit);
		fast = t + 1 + int'($urandom_range(0, 50));
		slow = (t > 0) ? int'($urandom_range(0, t - 1)) : 0;
		if ($urandom_range(0, 1))
			slow = -slow;
		case ($urandom_range(0, 6))
		0: return make_velocity(clamp16(fast), clamp16(slow));
		1: return make_velocity(clamp16(-fast), clamp16(slow));
		2: return make_velocity(clamp16(slow), clamp16(fast));
		3: return make_velocity(clamp16(slow), clamp16(-fast));
		4: return make_velocity(clamp16(t), clamp16(slow));
		5: return make_velocity(clamp16(-fast), clamp16(fast));
		default: return make_velocity(16'($urandom), 16'($urandom));
		endcase
	endfunction

	// Offer one item after a random gap and hold it until the block takes it.
	task automatic send_item(input lidar_item_t it);
		int gap;
		gap = $urandom_range(0, tx_gap_max);
		@(negedge clk);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		req_type <= it.kind;
		lidar_source <= it.src;
		point_x_mm <= it.px;
		point_y_mm <= it.py;
		point_z_mm <= it.pz;
		speed_x_mm_s <= it.vx;
		speed_y_mm_s <= it.vy;
		do @(posedge clk); while (full);
		predict_item(it);
	endtask

	// Stop offering, then wait for every pending frame result plus the pipeline tail.
	task automatic drain();
		@(negedge clk);
		push <= 1'b0;
		while (expected_frames.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input dbos_pkg::reg_idx_t idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
		dbos_pkg::REG_VEHICLE_LENGTH: cfg_length = value[13:0];
		dbos_pkg::REG_VEHICLE_WIDTH: cfg_width = value[13:0];
		dbos_pkg::REG_SAFETY_MARGIN: cfg_margin = value[13:0];
		dbos_pkg::REG_BOX_EXTENT: cfg_extent = value[13:0];
		dbos_pkg::REG_HEIGHT_LOW: cfg_z_low = value[15:0];
		dbos_pkg::REG_HEIGHT_HIGH: cfg_z_high = value[15:0];
		dbos_pkg::REG_COUNT_LIMIT: cfg_count_limit = value[15:0];
		dbos_pkg::REG_SPEED_LIMIT: cfg_speed_limit = value[14:0];
		default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic configure(input int len, input int wid, input int margin, input int extent,
			input int z_low, input int z_high, input int limit, input int speed);
		drain();
		write_reg(dbos_pkg::REG_VEHICLE_LENGTH, 32'(len));
		write_reg(dbos_pkg::REG_VEHICLE_WIDTH, 32'(wid));
		write_reg(dbos_pkg::REG_SAFETY_MARGIN, 32'(margin));
		write_reg(dbos_pkg::REG_BOX_EXTENT, 32'(extent));
		write_reg(dbos_pkg::REG_HEIGHT_LOW, 32'(z_low));
		write_reg(dbos_pkg::REG_HEIGHT_HIGH, 32'(z_high));
		write_reg(dbos_pkg::REG_COUNT_LIMIT, 32'(limit));
		write_reg(dbos_pkg::REG_SPEED_LIMIT, 32'(speed));
	endtask

	task automatic configure_moderate();
		int z_low;
		z_low = -int'($urandom_range(0, 1000));
		configure($urandom_range(0, 2000), $urandom_range(0, 2000), $urandom_range(0, 500),
			$urandom_range(0, 2000), z_low, z_low + int'($urandom_range(0, 1000)),
			$urandom_range(0, 8), $urandom_range(0, 500));
	endtask

	// One frame: maybe a new direction, a run of points with some noise, then the frame end.
	task automatic run_frame(input int npoints);
		int i;
		if ($urandom_range(0, 2) == 0)
			send_item(random_velocity());
		for (i = 0; i < npoints; i++) begin
			case ($urandom_range(0, 19))
			0: send_item(random_velocity());
			1: send_item(random_point(~lidar_sel));
			2: send_item(make_frame(~lidar_sel));
			3: send_item(make_unknown());
			default: send_item(near_point(lidar_sel));
			endcase
		end
		send_item(make_frame(lidar_sel));
	endtask

	// Box edges under the reset settings, ignored items, and every direction.
	task automatic test_directed();
		send_item(make_point(1'b0, 16'sd600, 16'sd0, -16'sd500));
		send_item(make_point(1'b0, 16'sd599, 16'sd0, -16'sd500));
		send_item(make_point(1'b0, 16'sd1600, 16'sd250, -16'sd1000));
		send_item(make_point(1'b0, 16'sd1000, -16'sd250, -16'sd300));
		send_item(make_point(1'b0, 16'sd1000, -16'sd251, -16'sd300));
		send_item(make_point(1'b0, 16'sd1000, 16'sd0, -16'sd299));
		send_item(make_point(1'b0, 16'sd1000, 16'sd0, -16'sd1001));
		send_item(make_point(1'b1, 16'sd1000, 16'sd0, -16'sd500));
		send_item(make_frame(1'b1));
		send_item(make_unknown());
		send_item(make_frame(1'b0));
		send_item(make_point(1'b0, 16'sh8000, 16'sh8000, 16'sh8000));
		send_item(make_point(1'b0, 16'sh7fff, 16'sh7fff, 16'sh7fff));
		send_item(make_velocity(16'sh8000, 16'sd0));
		send_item(make_point(1'b1, -16'sd600, 16'sd0, -16'sd500));
		// Speed exactly at the threshold stops the vehicle and keeps the second lidar.
		send_item(make_velocity(16'sd0, 16'sd200));
		send_item(make_point(1'b1, 16'sd0, 16'sd0, -16'sd500));
		// Switching lidars mid-frame keeps the running count.
		send_item(make_velocity(16'sd0, 16'sh7fff));
		send_item(make_point(1'b0, 16'sd0, 16'sd450, -16'sd500));
		send_item(make_frame(1'b0));
		send_item(make_velocity(16'sd0, -16'sd201));
		send_item(make_point(1'b1, 16'sd400, -16'sd450, -16'sd500));
		send_item(make_frame(1'b1));
		send_item(make_velocity(16'sd201, 16'sd0));
		drain();
	endtask

	// Hold the result side off while frame ends keep coming, so the block fills up.
	task automatic test_result_backpressure();
		int i;
		tx_gap_max = 0;
		@(posedge clk);
		rx_hold = 300;
		for (i = 0; i < 40; i++) begin
			if (i % 4 == 0)
				send_item(near_point(lidar_sel));
			send_item(make_frame(lidar_sel));
		end
		tx_gap_max = GAP_MAX;
		drain();
	endtask

	task automatic test_random_traffic();
		int phase, first;
		int z_low;
		for (phase = 0; phase < 6; phase++) begin
			case (phase)
			1: configure(0, 0, 0, 0, 0, 0, 0, 0);
			2: configure(16383, 16383, 16383, 16383, -32768, 32767, 65535, 32767);
			3: configure($urandom_range(0, 2000), $urandom_range(0, 2000),
				$urandom_range(0, 500), $urandom_range(0, 2000), 500, -500,
				$urandom_range(0, 8), $urandom_range(0, 500));
			5: begin
				z_low = int'($urandom_range(0, 65535)) - 32768;
				configure($urandom_range(0, 16383), $urandom_range(0, 16383),
					$urandom_range(0, 16383), $urandom_range(0, 16383), z_low,
					z_low + int'($urandom_range(0, 32767 - z_low)),
					$urandom_range(0, 65535), $urandom_range(0, 32767));
			end
			default: configure_moderate();
			endcase
			// One phase runs without any idling on either side.
			tx_gap_max = (phase == 4) ? 0 : GAP_MAX;
			rx_gap_max = (phase == 4) ? 0 : GAP_MAX;
			first = effective_items;
			while (effective_items - first < PHASE_ITEMS) begin
				run_frame($urandom_range(0, 14));
				// Early in this phase, let the sender sit idle until all results are out.
				if (phase == 3 && effective_items - first < 15)
					drain();
			end
		end
		tx_gap_max = GAP_MAX;
		rx_gap_max = GAP_MAX;
	endtask

	// One long frame of in-box points pushes the count over the limit, then a few
	// frames show the stop flag held by the history.
	task automatic test_long_frame();
		int i;
		configure(800, 500, 200, 1000, -1000, -300, 20, 200);
		tx_gap_max = 0;
		send_item(make_velocity(16'sd0, 16'sd0));
		for (i = 0; i < LONG_FRAME_POINTS; i++)
			send_item(make_point(lidar_sel, 16'sd0, 16'sd0, -16'sd500));
		send_item(make_frame(lidar_sel));
		tx_gap_max = GAP_MAX;
		for (i = 0; i < 3; i++)
			run_frame($urandom_range(0, 6));
		drain();
	endtask

	// Result side: random stalls between beats and a long hold when asked.
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			pop <= 1'b0;
			rx_hold--;
		end else if (rx_stall > 0) begin
			pop <= 1'b0;
			rx_stall--;
		end else begin
			pop <= 1'b1;
		end
	end

	// Compare every accepted result beat with the oldest expected frame.
	always @(posedge clk) begin
		dbos_pkg::result_t want;
		if (arst_n && pop && !empty) begin
			if (expected_frames.size() == 0) begin
				$error("unexpected result beat: obstacle_halt=%0b frame_points=%0d active_lidar=%0b",
					obstacle_halt, frame_points, active_lidar);
				errors++;
			end else begin
				want = expected_frames[0];
				expected_frames.delete(0);
				if (obstacle_halt !== want.stop) begin
					$error("obstacle_halt: expected %0b, got %0b", want.stop, obstacle_halt);
					errors++;
				end
				if (frame_points !== want.points) begin
					$error("frame_points: expected %0d, got %0d", want.points, frame_points);
					errors++;
				end
				if (active_lidar !== want.lidar) begin
					$error("active_lidar: expected %0b, got %0b", want.lidar, active_lidar);
					errors++;
				end
			end
			rx_stall = $urandom_range(0, rx_gap_max);
		end
	end

	initial begin
		reset_detector_model();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_result_backpressure();
		test_random_traffic();
		test_long_frame();
		drain();
		if (errors == 0)
			$display("[direction_box_obstacle_stop] OK");
		else
			$display("[direction_box_obstacle_stop] ERROR");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("[direction_box_obstacle_stop] ERROR");
		$finish;
	end

endmodule

// File: direction_box_obstacle_stop.f
sv/dbos_pkg.sv
sv/dbos_cfg.sv
sv/dbos_front.sv
sv/dbos_opq.sv
sv/dbos_back.sv
sv/direction_box_obstacle_stop.sv
sv/dbos_checker.sv
tb/direction_box_obstacle_stop_test.sv
